@@ rtl/core/bfs_pkg.sv @@
// bfs_pkg: shared sizes, op codes and control/status structs for the bit field store
// depends on: nothing
package bfs_pkg;

    // store geometry
    localparam int MAX_BITS   = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = $clog2(WORD_COUNT);
    localparam int KEEP_W     = WORD_AW + 1;

    // field widths
    localparam int OP_W     = 2;
    localparam int POS_W    = 12;
    localparam int LEN_W    = 6;
    localparam int ACTIVE_W = 13;
    localparam int OFF_W    = 5;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(MAX_BITS);
    localparam logic [ACTIVE_W-1:0] ACTIVE_MAX   = ACTIVE_W'(MAX_BITS);
    localparam logic [LEN_W-1:0]    LEN_MAX      = LEN_W'(WORD_BITS);

    // op codes
    localparam logic [OP_W-1:0] OP_RD_BIT   = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_BIT   = 2'd1;
    localparam logic [OP_W-1:0] OP_RD_FIELD = 2'd2;
    localparam logic [OP_W-1:0] OP_WR_FIELD = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic accept;    // latch request, issue read of low word
        logic rd_hi;     // capture low word, issue read of high word
        logic merge;     // extract / insert over the word pair
        logic wr_lo;     // write back low word
        logic wr_hi;     // write back high word
        logic out_load;  // move result into output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic do_wr_lo;
        logic do_wr_hi;
        logic out_full;
    } t_sts;

endpackage

@@ rtl/core/bfs_ram.sv @@
// bfs_ram: generic single-port ram, one access per cycle, registered read data
// depends on: nothing
module bfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write or registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/bfs_dp.sv @@
// bfs_dp: datapath of the bit field store: clamping, word pair merge, word ram,
// per-word valid bits, active bit count register and output register
// depends on: bfs_pkg, bfs_ram
module bfs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bfs_pkg::ACTIVE_W-1:0]    i_cfg_wdata,
    input  logic [bfs_pkg::OP_W-1:0]        i_op,
    input  logic [bfs_pkg::POS_W-1:0]       i_bit_pos,
    input  logic [bfs_pkg::LEN_W-1:0]       i_field_len,
    input  logic [bfs_pkg::WORD_BITS-1:0]   i_wdata,
    input  logic                            i_ready,
    input  bfs_pkg::t_cmd                   i_cmd,
    output bfs_pkg::t_sts                   o_sts,
    output logic                            o_valid,
    output logic [bfs_pkg::WORD_BITS-1:0]   o_rdata
);
    import bfs_pkg::*;

    localparam int PAIR_W = 2 * WORD_BITS;

    logic [ACTIVE_W-1:0]   r_active_bits;
    logic [WORD_COUNT-1:0] r_valid;
    logic [WORD_COUNT-1:0] n_valid;

    logic [OP_W-1:0]       r_op;
    logic [WORD_AW-1:0]    r_w;
    logic [OFF_W-1:0]      r_off;
    logic [LEN_W-1:0]      r_cnt;
    logic [WORD_BITS-1:0]  r_wdata;
    logic [WORD_BITS-1:0]  r_lo;
    logic [PAIR_W-1:0]     r_new_pair;
    logic                  r_span;
    logic [WORD_BITS-1:0]  r_rdata;
    logic                  r_out_valid;
    logic [WORD_BITS-1:0]  r_out_rdata;

    logic [ACTIVE_W-1:0]   nb;
    logic [ACTIVE_W-1:0]   rem;
    logic                  in_range;
    logic [LEN_W-1:0]      len_eff;
    logic [LEN_W-1:0]      len_c;
    logic [LEN_W-1:0]      cnt;

    logic [ACTIVE_W-1:0]   cfg_nb;
    logic [KEEP_W-1:0]     keep;

    logic [WORD_AW-1:0]    w_next;
    logic                  hi_beyond;
    logic                  is_wr;
    logic [WORD_BITS-1:0]  lo_word;
    logic [WORD_BITS-1:0]  hi_word;
    logic [WORD_BITS-1:0]  low_mask;
    logic [PAIR_W-1:0]     mask;
    logic [PAIR_W-1:0]     pair;
    logic [PAIR_W-1:0]     rd_pair;
    logic [PAIR_W-1:0]     ins;

    logic                  ram_we;
    logic [WORD_AW-1:0]    ram_addr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_BITS-1:0]  ram_rdata;

    // effective bit count and request clamping
    always_comb begin
        nb       = (r_active_bits > ACTIVE_MAX) ? ACTIVE_MAX : r_active_bits;
        in_range = {1'b0, i_bit_pos} < nb;
        rem      = nb - {1'b0, i_bit_pos};
        len_eff  = (i_op == OP_RD_BIT || i_op == OP_WR_BIT) ? LEN_W'(1) : i_field_len;
        len_c    = (len_eff > LEN_MAX) ? LEN_MAX : len_eff;
        if (!in_range) begin
            cnt = '0;
        end else if (rem < ACTIVE_W'(len_c)) begin
            cnt = rem[LEN_W-1:0];
        end else begin
            cnt = len_c;
        end
    end

    // request registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_w     <= i_bit_pos[POS_W-1:OFF_W];
            r_off   <= i_bit_pos[OFF_W-1:0];
            r_cnt   <= cnt;
            r_wdata <= i_wdata;
        end
    end

    // word pair gathering; unwritten words and the word past the store read as zero
    assign w_next    = r_w + 1'b1;
    assign hi_beyond = (r_w == WORD_AW'(WORD_COUNT - 1));
    assign is_wr     = (r_op == OP_WR_BIT || r_op == OP_WR_FIELD);
    assign lo_word   = r_valid[r_w] ? ram_rdata : '0;
    assign hi_word   = (r_valid[w_next] && !hi_beyond) ? ram_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_hi) begin
            r_lo <= lo_word;
        end
    end

    // extract and insert over the pair
    always_comb begin
        low_mask = (r_cnt == LEN_MAX) ? '1
                 : ((WORD_BITS'(1) << r_cnt) - WORD_BITS'(1));
        mask     = {{WORD_BITS{1'b0}}, low_mask} << r_off;
        pair     = {hi_word, r_lo};
        rd_pair  = (pair & mask) >> r_off;
        ins      = ({{WORD_BITS{1'b0}}, r_wdata} << r_off) & mask;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.merge) begin
            r_new_pair <= (pair & ~mask) | ins;
            r_rdata    <= is_wr ? '0 : rd_pair[WORD_BITS-1:0];
            r_span     <= ({1'b0, r_off} + r_cnt) > (LEN_W'(WORD_BITS));
        end
    end

    // word ram port
    always_comb begin
        ram_we    = i_cmd.wr_lo || i_cmd.wr_hi;
        ram_wdata = i_cmd.wr_hi ? r_new_pair[PAIR_W-1:WORD_BITS]
                                : r_new_pair[WORD_BITS-1:0];
        if (i_cmd.accept) begin
            ram_addr = i_bit_pos[POS_W-1:OFF_W];
        end else if (i_cmd.rd_hi || i_cmd.wr_hi) begin
            ram_addr = w_next;
        end else begin
            ram_addr = r_w;
        end
    end

    bfs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // word count kept after a bit count write
    always_comb begin
        cfg_nb = (i_cfg_wdata > ACTIVE_MAX) ? ACTIVE_MAX : i_cfg_wdata;
        keep   = KEEP_W'((cfg_nb + ACTIVE_W'(WORD_BITS - 1)) >> OFF_W);
    end

    // valid bits: set on write-back, dropped for words past the new bit count
    always_comb begin
        n_valid = r_valid;
        if (i_cfg_we) begin
            for (int i = 0; i < WORD_COUNT; i++) begin
                if (KEEP_W'(i) >= keep) begin
                    n_valid[i] = 1'b0;
                end
            end
        end else begin
            if (i_cmd.wr_lo) begin
                n_valid[r_w] = 1'b1;
            end
            if (i_cmd.wr_hi) begin
                n_valid[w_next] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_active_bits <= ACTIVE_RESET;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_active_bits <= i_cfg_wdata;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_rdata <= r_rdata;
        end
    end

    // status
    assign o_sts.do_wr_lo = is_wr && (r_cnt != '0);
    assign o_sts.do_wr_hi = is_wr && r_span && !hi_beyond;
    assign o_sts.out_full = r_out_valid && !i_ready;

    assign o_valid = r_out_valid;
    assign o_rdata = r_out_rdata;

endmodule

@@ rtl/core/bfs_ctrl.sv @@
// bfs_ctrl: controller state machine sequencing read, merge and write-back
// depends on: bfs_pkg
module bfs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  bfs_pkg::t_sts i_sts,
    output logic          o_ready,
    output bfs_pkg::t_cmd o_cmd
);
    import bfs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD_HI = 3'd1;
    localparam logic [2:0] ST_MERGE = 3'd2;
    localparam logic [2:0] ST_WR_LO = 3'd3;
    localparam logic [2:0] ST_WR_HI = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = ST_RD_HI;
                end
            end
            ST_RD_HI: begin
                o_cmd.rd_hi = 1'b1;
                n_state     = ST_MERGE;
            end
            ST_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = i_sts.do_wr_lo ? ST_WR_LO : ST_DONE;
            end
            ST_WR_LO: begin
                o_cmd.wr_lo = 1'b1;
                n_state     = i_sts.do_wr_hi ? ST_WR_HI : ST_DONE;
            end
            ST_WR_HI: begin
                o_cmd.wr_hi = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/bit_field_store.sv @@
// bit_field_store: bit array of 4096 bits in 32-bit words with bit and field access
// steps: accept in idle, read high word, merge, write back low and high word as needed, then
// load the result, held while the receiver stalls; one request at a time over a single ram port
// reset: synchronous active low, store reads as all zeros via per-word valid bits, bit count 4096
// depends on: bfs_pkg, bfs_ctrl, bfs_dp, bfs_ram
module bit_field_store (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bfs_pkg::ACTIVE_W-1:0]    i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bfs_pkg::OP_W-1:0]        i_op,
    input  logic [bfs_pkg::POS_W-1:0]       i_bit_pos,
    input  logic [bfs_pkg::LEN_W-1:0]       i_field_len,
    input  logic [bfs_pkg::WORD_BITS-1:0]   i_wdata,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bfs_pkg::WORD_BITS-1:0]   o_rdata
);
    import bfs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    bfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    // datapath and store
    bfs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (i_op),
        .i_bit_pos   (i_bit_pos),
        .i_field_len (i_field_len),
        .i_wdata     (i_wdata),
        .i_ready     (i_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .o_rdata     (o_rdata)
    );

endmodule

@@ tb/sv/bfs_store_checker.sv @@
// bfs_store_checker: watches the request and result channels of bit_field_store,
// keeps its own copy of the bit array and bit count, and compares every result word
// depends on: bfs_pkg
`timescale 1ns / 1ps

module bfs_store_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bfs_pkg::ACTIVE_W-1:0]     i_cfg_wdata,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [bfs_pkg::OP_W-1:0]         i_op,
    input  logic [bfs_pkg::POS_W-1:0]        i_bit_pos,
    input  logic [bfs_pkg::LEN_W-1:0]        i_field_len,
    input  logic [bfs_pkg::WORD_BITS-1:0]    i_wdata,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [bfs_pkg::WORD_BITS-1:0]    i_rdata,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);
    import bfs_pkg::*;

    localparam int PRINT_LIMIT = 50;

    logic [WORD_BITS-1:0] shadow_words [WORD_COUNT];
    logic [ACTIVE_W-1:0]  shadow_active = ACTIVE_RESET;
    logic [WORD_BITS-1:0] rdata_expected [$];
    logic [WORD_BITS-1:0] expected_rdata;
    int unsigned          keep_words;
    int                   fail_count = 0;
    int                   pending_words = 0;
    int                   checked_words = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_words;
    assign o_checked    = checked_words;

    // bit count in effect: values above the store size act as the store size
    function automatic int unsigned bits_in_use();
        return (shadow_active > ACTIVE_MAX) ? MAX_BITS : int'(shadow_active);
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("%0t ns  mismatch: %s", $time, what);
        end
    endtask

    // apply one request to the shadow array and return the word it reads back
    function automatic logic [WORD_BITS-1:0] predict_access(
        input logic [OP_W-1:0]      op,
        input logic [POS_W-1:0]     pos,
        input logic [LEN_W-1:0]     len,
        input logic [WORD_BITS-1:0] wdata
    );
        int unsigned          nb;
        int unsigned          start;
        int unsigned          cnt;
        int unsigned          w;
        int unsigned          off;
        logic [63:0]          pair;
        logic [63:0]          mask;
        logic [WORD_BITS-1:0] result;
        result = '0;
        nb = bits_in_use();
        if (op == OP_RD_BIT || op == OP_WR_BIT) begin
            // single bit, ignored at or beyond the bit count
            if (pos < nb) begin
                w   = pos >> 5;
                off = pos[OFF_W-1:0];
                if (op == OP_RD_BIT) begin
                    result = WORD_BITS'(shadow_words[w][off]);
                end else begin
                    shadow_words[w][off] = wdata[0];
                end
            end
        end else begin
            // field: clamp start to the count, length to 32 and to what remains
            start = (pos < nb) ? pos : nb;
            cnt   = len;
            if (cnt > nb - start) cnt = nb - start;
            if (cnt > WORD_BITS) cnt = WORD_BITS;
            w   = start >> 5;
            off = start % WORD_BITS;
            pair[31:0]  = (w < WORD_COUNT) ? shadow_words[w] : '0;
            pair[63:32] = (w + 1 < WORD_COUNT) ? shadow_words[w + 1] : '0;
            mask = ((64'd1 << cnt) - 64'd1) << off;
            if (op == OP_RD_FIELD) begin
                result = WORD_BITS'((pair & mask) >> off);
            end else if (cnt != 0) begin
                pair = (pair & ~mask) | ((64'(wdata) << off) & mask);
                if (w < WORD_COUNT) shadow_words[w] = pair[31:0];
                // second word only when the field crosses into it and it exists
                if (off + cnt > WORD_BITS && w + 1 < WORD_COUNT) begin
                    shadow_words[w + 1] = pair[63:32];
                end
            end
        end
        return result;
    endfunction

    // follow config writes, requests and results edge by edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (shadow_words[w]) shadow_words[w] = '0;
            shadow_active = ACTIVE_RESET;
            rdata_expected.delete();
        end else begin
            // new bit count clears every word wholly outside it
            if (i_cfg_we) begin
                shadow_active = i_cfg_wdata;
                keep_words = (bits_in_use() + 31) >> 5;
                for (int w = 0; w < WORD_COUNT; w++) begin
                    if (w >= keep_words) shadow_words[w] = '0;
                end
            end
            if (i_in_valid && i_in_ready) begin
                rdata_expected.push_back(predict_access(i_op, i_bit_pos, i_field_len, i_wdata));
            end
            // result word against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (rdata_expected.size() == 0) begin
                    report_mismatch($sformatf("result word %h with nothing expected", i_rdata));
                end else begin
                    expected_rdata = rdata_expected.pop_front();
                    checked_words++;
                    if (i_rdata !== expected_rdata) begin
                        report_mismatch($sformatf("rdata %h, expected %h (result %0d)",
                                                  i_rdata, expected_rdata, checked_words));
                    end
                end
            end
        end
        pending_words <= rdata_expected.size();
    end

endmodule

@@ tb/sv/bit_field_store_test.sv @@
// bit_field_store_test: drives bit and field requests into bit_field_store under
// several bit counts, with bursty input, receiver stalls and one long hold-off
// depends on: bfs_pkg, bit_field_store, bfs_store_checker
`timescale 1ns / 1ps

module bit_field_store_test;
    import bfs_pkg::*;

    localparam int PHASES      = 9;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [ACTIVE_W-1:0]  i_cfg_wdata = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [OP_W-1:0]      i_op = OP_RD_BIT;
    logic [POS_W-1:0]     i_bit_pos = '0;
    logic [LEN_W-1:0]     i_field_len = '0;
    logic [WORD_BITS-1:0] i_wdata = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [WORD_BITS-1:0] o_rdata;

    int fail_count;
    int pending;
    int checked;

    // bit count per random phase, -1 picks one at random
    int phase_bits [PHASES]  = '{4096, 100, 4096, 1, 0, 8191, 33, -1, 4095};
    int phase_items [PHASES] = '{160, 100, 160, 30, 20, 140, 60, 150, 100};

    int op_count [4] = '{0, 0, 0, 0};
    int settings_used = 0;
    int cur_active = MAX_BITS;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;

    bit_field_store dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_bit_pos   (i_bit_pos),
        .i_field_len (i_field_len),
        .i_wdata     (i_wdata),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rdata     (o_rdata)
    );

    bfs_store_checker u_store_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_op         (i_op),
        .i_bit_pos    (i_bit_pos),
        .i_field_len  (i_field_len),
        .i_wdata      (i_wdata),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_rdata      (o_rdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // offer one request word, hold it until taken, then maybe open a gap
    task automatic send_word(
        input logic [OP_W-1:0]      op,
        input logic [POS_W-1:0]     pos,
        input logic [LEN_W-1:0]     len,
        input logic [WORD_BITS-1:0] wdata
    );
        int gap;
        i_valid     <= 1'b1;
        i_op        <= op;
        i_bit_pos   <= pos;
        i_field_len <= len;
        i_wdata     <= wdata;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        op_count[op]++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 10);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    // write the bit count once the block has drained
    task automatic set_active(input int value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // field writes finish their write-back before their result word is loaded
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ACTIVE_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_active = value;
        settings_used++;
    endtask

    // receiver: stall patterns of varying length, plus a long hold-off on request
    initial begin
        int mode;
        int seg_len;
        int tick;
        tick = 0;
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(20, 200);
            repeat (seg_len) begin
                @(posedge i_clk);
                tick++;
                if (hold_req) begin
                    i_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_req = 1'b0;
                end else begin
                    case (mode)
                        0: begin
                            i_ready <= 1'b1;
                        end
                        1: begin
                            i_ready <= 1'($urandom_range(0, 1));
                        end
                        2: begin
                            i_ready <= (tick % 5) < 3;
                        end
                        default: begin
                            i_ready <= ($urandom_range(0, 7) == 0);
                        end
                    endcase
                end
            end
        end
    end

    // stimulus and verdict
    initial begin
        int nb;
        int base;
        int sel;
        int p;
        int drain;
        bit last_was_write;
        logic [OP_W-1:0]      op;
        logic [POS_W-1:0]     pos;
        logic [LEN_W-1:0]     len;
        logic [WORD_BITS-1:0] data;

        last_was_write = 1'b0;
        pos = '0;
        len = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset bit count, bit extremes, spanning and clamped fields
        send_word(OP_RD_BIT,   12'd0,    6'd0,  32'h0000_0000);
        send_word(OP_WR_BIT,   12'd0,    6'd0,  32'hFFFF_FFFF);
        send_word(OP_RD_BIT,   12'd0,    6'd0,  32'h0000_0000);
        send_word(OP_WR_BIT,   12'd4095, 6'd0,  32'h0000_0001);
        send_word(OP_RD_BIT,   12'd4095, 6'd0,  32'h0000_0000);
        send_word(OP_WR_FIELD, 12'd20,   6'd32, 32'hA5C3_0F96);
        send_word(OP_RD_FIELD, 12'd16,   6'd32, 32'h0000_0000);
        send_word(OP_WR_FIELD, 12'd40,   6'd0,  32'hFFFF_FFFF);
        send_word(OP_RD_FIELD, 12'd40,   6'd0,  32'h0000_0000);
        send_word(OP_WR_FIELD, 12'd4080, 6'd32, 32'hDEAD_BEEF);
        send_word(OP_RD_FIELD, 12'd4064, 6'd32, 32'h0000_0000);
        send_word(OP_WR_FIELD, 12'd4064, 6'd32, 32'hFFFF_FFFF);
        send_word(OP_RD_FIELD, 12'd4095, 6'd32, 32'h0000_0000);
        send_word(OP_WR_FIELD, 12'd31,   6'd1,  32'h0000_0000);
        send_word(OP_RD_FIELD, 12'd0,    6'd32, 32'h0000_0000);
        // small bit count: reads beyond give zero, writes beyond drop
        set_active(100);
        send_word(OP_RD_BIT,   12'd100,  6'd0,  32'h0000_0000);
        send_word(OP_WR_BIT,   12'd120,  6'd0,  32'hFFFF_FFFF);
        send_word(OP_WR_FIELD, 12'd90,   6'd32, 32'hFFFF_FFFF);
        send_word(OP_RD_FIELD, 12'd64,   6'd32, 32'h0000_0000);
        send_word(OP_RD_FIELD, 12'd4095, 6'd32, 32'h0000_0000);
        // zero bit count: everything empty
        set_active(0);
        send_word(OP_WR_FIELD, 12'd0,    6'd32, 32'hFFFF_FFFF);
        send_word(OP_RD_BIT,   12'd0,    6'd0,  32'h0000_0000);
        // oversized bit count acts as the full store
        set_active(8191);
        send_word(OP_RD_FIELD, 12'd4094, 6'd32, 32'h0000_0000);
        send_word(OP_WR_BIT,   12'd4095, 6'd0,  32'h0000_0001);
        send_word(OP_RD_BIT,   12'd4095, 6'd0,  32'h0000_0000);

        // random phases, one bit count each
        for (int ph = 0; ph < PHASES; ph++) begin
            set_active(phase_bits[ph] < 0 ? $urandom_range(1, 8191) : phase_bits[ph]);
            nb      = (cur_active > MAX_BITS) ? MAX_BITS : cur_active;
            base    = (nb > 96) ? $urandom_range(0, nb - 96) : 0;
            gaps_on = (ph != 2) && (ph != 6);
            // long hold-off while words keep coming with no gaps
            if (ph == 2) hold_req = 1'b1;
            for (int k = 0; k < phase_items[ph]; k++) begin
                if (last_was_write && $urandom_range(0, 2) == 0) begin
                    // read back what was just written
                    op = OP_RD_FIELD;
                end else begin
                    op  = OP_W'($urandom_range(0, 3));
                    sel = $urandom_range(0, 9);
                    if (sel <= 4) begin
                        p = base + $urandom_range(0, 95);
                    end else if (sel <= 6) begin
                        p = $urandom_range(0, 127) * WORD_BITS +
                            ($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(29, 31));
                    end else if (sel == 7) begin
                        p = nb + $urandom_range(0, 40) - 20;
                    end else begin
                        p = $urandom_range(0, MAX_BITS - 1);
                    end
                    if (p < 0) p = 0;
                    if (p > MAX_BITS - 1) p = MAX_BITS - 1;
                    pos = POS_W'(p);
                    case ($urandom_range(0, 7))
                        0:       len = '0;
                        1:       len = LEN_MAX;
                        2:       len = LEN_W'(1);
                        3:       len = LEN_W'(31);
                        default: len = LEN_W'($urandom_range(0, 32));
                    endcase
                end
                case ($urandom_range(0, 7))
                    0:       data = '1;
                    1:       data = '0;
                    default: data = $urandom;
                endcase
                last_was_write = (op == OP_WR_BIT || op == OP_WR_FIELD);
                send_word(op, pos, len, data);
            end
        end

        // drain what is still in flight
        i_valid <= 1'b0;
        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        if (pending != 0) begin
            $display("%0d expected result words never arrived", pending);
        end

        $display("%0d requests: %0d bit reads, %0d bit writes, %0d field reads, %0d field writes",
                 op_count[OP_RD_BIT] + op_count[OP_WR_BIT] + op_count[OP_RD_FIELD] +
                 op_count[OP_WR_FIELD], op_count[OP_RD_BIT], op_count[OP_WR_BIT],
                 op_count[OP_RD_FIELD], op_count[OP_WR_FIELD]);
        $display("%0d bit count writes, %0d result words compared, %0d mismatches",
                 settings_used, checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // hard stop if the run hangs
    initial begin
        #5_000_000;
        $display("timeout with %0d result words outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bfs_pkg.sv
rtl/core/bfs_ram.sv
rtl/core/bfs_dp.sv
rtl/core/bfs_ctrl.sv
rtl/core/bit_field_store.sv
tb/sv/bfs_store_checker.sv
tb/sv/bit_field_store_test.sv
